// File: rtl/lzwd_pkg.sv
// shared types and constants for the lzw variable width decoder
package lzwd_pkg;

    localparam int LITERALS      = 256;
    localparam int MIN_CODE_BITS = 9;
    localparam int CHUNK_BYTES   = 64;

    typedef struct packed {
        logic [11:0] code_word;
        logic        starts_stream;
    } t_in;

    typedef struct packed {
        logic [63:0] bytes_lane0;
        logic [63:0] bytes_lane1;
        logic [63:0] bytes_lane2;
        logic [63:0] bytes_lane3;
        logic [63:0] bytes_lane4;
        logic [63:0] bytes_lane5;
        logic [63:0] bytes_lane6;
        logic [63:0] bytes_lane7;
        logic [6:0]  byte_count;
        logic        last_chunk;
        logic [3:0]  code_length;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_DAT,
        ST_WALK_END,
        ST_POP_RD,
        ST_POP_WR,
        ST_POP_X,
        ST_EMIT
    } t_state;

endpackage

// File: rtl/lzwd_front.sv
// input side: accepts code words into a four entry queue
module lzwd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lzwd_pkg::t_in    i_data,
    output logic             o_stall,
    output logic             o_q_valid,
    output lzwd_pkg::t_in    o_q_data,
    input  logic             i_q_pop
);

    lzwd_pkg::t_in r_mem [4];
    logic [1:0] r_wp, n_wp;
    logic [1:0] r_rp, n_rp;
    logic [2:0] r_count, n_count;
    logic       push, pop;

    assign o_stall   = (r_count == 3'd4);
    assign o_q_valid = (r_count != 3'd0);
    assign o_q_data  = r_mem[r_rp];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_wp    = push ? r_wp + 2'd1 : r_wp;
        n_rp    = pop ? r_rp + 2'd1 : r_rp;
        n_count = r_count + {2'd0, push} - {2'd0, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// File: rtl/lzwd_back.sv
// decoding side: dictionary walk, reverse stack and chunk assembly
module lzwd_back #(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  lzwd_pkg::t_in    i_q_data,
    output logic             o_q_pop,
    output logic             o_valid,
    output lzwd_pkg::t_out   o_data,
    input  logic             i_stall
);

    localparam int DICT_DEPTH  = (1 << MAX_CODE_BITS) - lzwd_pkg::LITERALS;
    localparam int AW          = $clog2(DICT_DEPTH);
    localparam int STACK_DEPTH = DICT_DEPTH + 1;
    localparam int SW          = $clog2(STACK_DEPTH);
    localparam int CODE_LIMIT  = 1 << MAX_CODE_BITS;

    logic [19:0] r_dict [DICT_DEPTH];
    logic [19:0] r_dict_q;
    logic [7:0]  r_stack [STACK_DEPTH];
    logic [7:0]  r_stack_q;

    lzwd_pkg::t_state r_state, n_state;

    logic [11:0]  r_c, n_c;
    logic [11:0]  r_code_eff, n_code_eff;
    logic         r_extra, n_extra;
    logic [7:0]   r_xbyte, n_xbyte;
    logic [SW-1:0] r_depth, n_depth;
    logic [SW-1:0] r_p, n_p;
    logic [511:0] r_chunk, n_chunk;
    logic [6:0]   r_cnt, n_cnt;
    logic         r_more, n_more;
    logic [12:0]  r_nfc, n_nfc;
    logic [11:0]  r_prev, n_prev;
    logic [7:0]   r_pfb, n_pfb;
    logic [3:0]   r_width, n_width;
    logic         r_await, n_await;
    lzwd_pkg::t_out r_out, n_out;
    logic         r_out_valid, n_out_valid;

    logic [12:0] eff_nfc;
    logic [11:0] eff_prev;
    logic [7:0]  eff_pfb;
    logic [3:0]  eff_width;
    logic        eff_await;
    logic [11:0] mask, code_m;
    logic        is_marker, known;
    logic        out_free;
    logic [7:0]  put_byte;
    logic        remaining;
    logic [6:0]  cnt_inc;
    logic [11:0] walk_code;
    logic [AW-1:0] dict_raddr, dict_waddr;
    logic        dict_we, stack_we, stack_re;
    logic [SW-1:0] stack_waddr, stack_raddr;
    logic [7:0]  stack_wdata;

    assign eff_nfc   = i_q_data.starts_stream ? 13'(lzwd_pkg::LITERALS) : r_nfc;
    assign eff_prev  = i_q_data.starts_stream ? 12'd0 : r_prev;
    assign eff_pfb   = i_q_data.starts_stream ? 8'd0 : r_pfb;
    assign eff_width = i_q_data.starts_stream ? 4'(lzwd_pkg::MIN_CODE_BITS) : r_width;
    assign eff_await = i_q_data.starts_stream ? 1'b1 : r_await;
    assign mask      = ~(12'hFFF << eff_width);
    assign code_m    = i_q_data.code_word & mask;
    assign is_marker = (code_m == mask) && (eff_width < 4'(MAX_CODE_BITS));
    assign known     = ({1'b0, code_m} < eff_nfc);
    assign out_free  = !r_out_valid || !i_stall;
    assign o_q_pop   = (r_state == lzwd_pkg::ST_IDLE) && i_q_valid;
    assign put_byte  = (r_state == lzwd_pkg::ST_POP_X) ? r_xbyte : r_stack_q;
    assign remaining = (r_state == lzwd_pkg::ST_POP_WR) && ((r_p != '0) || r_extra);
    assign cnt_inc   = r_cnt + 7'd1;

    // memory port control
    assign walk_code   = (r_state == lzwd_pkg::ST_WALK_DAT) ? r_dict_q[19:8] : r_c;
    assign dict_raddr  = AW'(walk_code - 12'(lzwd_pkg::LITERALS));
    assign dict_waddr  = AW'(r_nfc[11:0] - 12'(lzwd_pkg::LITERALS));
    assign dict_we     = (r_state == lzwd_pkg::ST_WALK_END) && (r_nfc < 13'(CODE_LIMIT));
    assign stack_we    = (r_state == lzwd_pkg::ST_WALK_DAT) || (r_state == lzwd_pkg::ST_WALK_END);
    assign stack_waddr = r_depth;
    assign stack_wdata = (r_state == lzwd_pkg::ST_WALK_DAT) ? r_dict_q[7:0] : r_c[7:0];
    assign stack_re    = (r_state == lzwd_pkg::ST_POP_RD) && (r_p != '0);
    assign stack_raddr = r_p - SW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lzwd_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    if (eff_await || is_marker) begin
                        n_state = lzwd_pkg::ST_EMIT;
                    end else if ((known ? code_m : eff_prev) >= 12'(lzwd_pkg::LITERALS)) begin
                        n_state = lzwd_pkg::ST_WALK_RD;
                    end else begin
                        n_state = lzwd_pkg::ST_WALK_END;
                    end
                end
            end
            lzwd_pkg::ST_WALK_RD:  n_state = lzwd_pkg::ST_WALK_DAT;
            lzwd_pkg::ST_WALK_DAT: begin
                if (r_dict_q[19:8] < 12'(lzwd_pkg::LITERALS)) begin
                    n_state = lzwd_pkg::ST_WALK_END;
                end
            end
            lzwd_pkg::ST_WALK_END: n_state = lzwd_pkg::ST_POP_RD;
            lzwd_pkg::ST_POP_RD: begin
                n_state = (r_p != '0) ? lzwd_pkg::ST_POP_WR : lzwd_pkg::ST_POP_X;
            end
            lzwd_pkg::ST_POP_WR: begin
                n_state = ((cnt_inc == 7'(lzwd_pkg::CHUNK_BYTES)) || !remaining)
                          ? lzwd_pkg::ST_EMIT : lzwd_pkg::ST_POP_RD;
            end
            lzwd_pkg::ST_POP_X:    n_state = lzwd_pkg::ST_EMIT;
            lzwd_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = r_more ? lzwd_pkg::ST_POP_RD : lzwd_pkg::ST_IDLE;
                end
            end
            default: n_state = lzwd_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_c         = r_c;
        n_code_eff  = r_code_eff;
        n_extra     = r_extra;
        n_xbyte     = r_xbyte;
        n_depth     = r_depth;
        n_p         = r_p;
        n_chunk     = r_chunk;
        n_cnt       = r_cnt;
        n_more      = r_more;
        n_nfc       = r_nfc;
        n_prev      = r_prev;
        n_pfb       = r_pfb;
        n_width     = r_width;
        n_await     = r_await;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            lzwd_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    n_nfc   = eff_nfc;
                    n_prev  = eff_prev;
                    n_pfb   = eff_pfb;
                    n_width = eff_width;
                    n_await = eff_await;
                    n_depth = '0;
                    n_more  = 1'b0;
                    n_chunk = '0;
                    n_cnt   = '0;
                    if (eff_await) begin
                        n_chunk[7:0] = code_m[7:0];
                        n_cnt        = 7'd1;
                        n_prev       = {4'd0, code_m[7:0]};
                        n_pfb        = code_m[7:0];
                        n_await      = 1'b0;
                    end else if (is_marker) begin
                        n_width = eff_width + 4'd1;
                    end else if (known) begin
                        n_c        = code_m;
                        n_code_eff = code_m;
                        n_extra    = 1'b0;
                    end else begin
                        n_c        = eff_prev;
                        n_code_eff = eff_nfc[11:0];
                        n_extra    = 1'b1;
                        n_xbyte    = eff_pfb;
                    end
                end
            end
            lzwd_pkg::ST_WALK_RD: begin
            end
            lzwd_pkg::ST_WALK_DAT: begin
                n_depth = r_depth + SW'(1);
                n_c     = r_dict_q[19:8];
            end
            lzwd_pkg::ST_WALK_END: begin
                n_p    = r_depth + SW'(1);
                n_prev = r_code_eff;
                n_pfb  = r_c[7:0];
                if (r_nfc < 13'(CODE_LIMIT)) begin
                    n_nfc = r_nfc + 13'd1;
                end
            end
            lzwd_pkg::ST_POP_RD: begin
                if (r_p != '0) begin
                    n_p = r_p - SW'(1);
                end
            end
            lzwd_pkg::ST_POP_WR, lzwd_pkg::ST_POP_X: begin
                n_chunk[r_cnt[5:0]*8 +: 8] = put_byte;
                n_cnt  = cnt_inc;
                n_more = remaining;
                if (r_state == lzwd_pkg::ST_POP_X) begin
                    n_extra = 1'b0;
                end
            end
            lzwd_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_out.bytes_lane0 = r_chunk[63:0];
                    n_out.bytes_lane1 = r_chunk[127:64];
                    n_out.bytes_lane2 = r_chunk[191:128];
                    n_out.bytes_lane3 = r_chunk[255:192];
                    n_out.bytes_lane4 = r_chunk[319:256];
                    n_out.bytes_lane5 = r_chunk[383:320];
                    n_out.bytes_lane6 = r_chunk[447:384];
                    n_out.bytes_lane7 = r_chunk[511:448];
                    n_out.byte_count  = r_cnt;
                    n_out.last_chunk  = !r_more;
                    n_out.code_length = r_width;
                    n_out_valid       = 1'b1;
                    n_chunk           = '0;
                    n_cnt             = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lzwd_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_more      <= 1'b0;
            r_extra     <= 1'b0;
            r_nfc       <= 13'(lzwd_pkg::LITERALS);
            r_prev      <= '0;
            r_pfb       <= '0;
            r_width     <= 4'(lzwd_pkg::MIN_CODE_BITS);
            r_await     <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_more      <= n_more;
            r_extra     <= n_extra;
            r_nfc       <= n_nfc;
            r_prev      <= n_prev;
            r_pfb       <= n_pfb;
            r_width     <= n_width;
            r_await     <= n_await;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c        <= n_c;
        r_code_eff <= n_code_eff;
        r_xbyte    <= n_xbyte;
        r_depth    <= n_depth;
        r_p        <= n_p;
        r_chunk    <= n_chunk;
        r_out      <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (dict_we) begin
            r_dict[dict_waddr] <= {r_prev, r_c[7:0]};
        end
        r_dict_q <= r_dict[dict_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stack_we) begin
            r_stack[stack_waddr] <= stack_wdata;
        end
        if (stack_re) begin
            r_stack_q <= r_stack[stack_raddr];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 7'(lzwd_pkg::CHUNK_BYTES))
        else $error("chunk byte count overflow");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lzwd_pkg::ST_IDLE) |-> (r_cnt == 7'd0))
        else $error("chunk not drained before next code");

    a_pop_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state != lzwd_pkg::ST_IDLE))
        else $error("queue pop without decoding");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_width >= 4'(lzwd_pkg::MIN_CODE_BITS)) && (r_width <= 4'(MAX_CODE_BITS)))
        else $error("code width out of range");

endmodule

// File: rtl/lzw_variable_width_decoder.sv
// top level of the lzw variable width decoder
// decoding: each code word is expanded by a one-step-per-cycle dictionary walk and the
//   read-then-write pop of the reverse stack into chunks of up to 64 bytes; a new code
//   word is popped only in the idle state, after the previous one is fully emitted; the
//   queue takes transfers meanwhile
// reset: synchronous, active low; clears control state, dictionary memories stay undefined
module lzw_variable_width_decoder #(
    parameter int MAX_CODE_BITS = 12
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lzwd_pkg::t_in    i_data,
    output logic             o_stall,
    output logic             o_valid,
    output lzwd_pkg::t_out   o_data,
    input  logic             i_stall
);

    logic          q_valid;
    lzwd_pkg::t_in q_data;
    logic          q_pop;

    lzwd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_data    (i_data),
        .o_stall   (o_stall),
        .o_q_valid (q_valid),
        .o_q_data  (q_data),
        .i_q_pop   (q_pop)
    );

    lzwd_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the lzw variable width decoder
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXB       = 12;
    localparam int WATCHDOG   = 200000;
    localparam int DRAIN_WAIT = 400;

    typedef struct {
        logic [11:0] pre[3840];
        logic [7:0]  suf[3840];
        int          nf;
        logic [11:0] prev;
        logic [7:0]  pfirst;
        int          width;
        bit          fresh;
    } t_dict;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    lzwd_pkg::t_in  i_data;
    logic   o_stall;
    logic   o_valid;
    lzwd_pkg::t_out o_data;
    logic   i_stall;

    lzwd_pkg::t_in  pending_q[$];
    lzwd_pkg::t_out chunk_q[$];
    lzwd_pkg::t_out scratch_q[$];
    t_dict  gen_dict;
    t_dict  chk_dict;
    int     send_idle_pct;
    int     recv_stall_pct;
    int     errors;
    int     quiet_cycles;
    bit     in_fire;
    bit     out_fire;

    lzw_variable_width_decoder #(.MAX_CODE_BITS(MAXB)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    // expands one code word into its output chunks and updates the dictionary
    function automatic void decode_code(ref t_dict d, input lzwd_pkg::t_in it,
                                        ref lzwd_pkg::t_out res[$]);
        int          code;
        int          mask;
        int          cw;
        int          n;
        int          depth;
        int          i;
        int          k;
        int          cnt;
        logic [7:0]  rev[4100];
        logic [7:0]  str[4100];
        logic [7:0]  first;
        logic [511:0] flat;
        lzwd_pkg::t_out o;
        if (it.starts_stream) begin
            d.nf = lzwd_pkg::LITERALS;
            d.prev = '0;
            d.pfirst = '0;
            d.width = lzwd_pkg::MIN_CODE_BITS;
            d.fresh = 1'b1;
        end
        mask = (1 << d.width) - 1;
        code = int'(it.code_word) & mask;
        n = 0;
        if (d.fresh) begin
            str[0] = 8'(code);
            n = 1;
            d.prev = 12'(code & 8'hFF);
            d.pfirst = 8'(code);
            d.fresh = 1'b0;
        end else if (code == mask && d.width < MAXB) begin
            d.width++;
            o = '0;
            o.last_chunk = 1'b1;
            o.code_length = 4'(d.width);
            res.push_back(o);
            return;
        end else begin
            cw = (code < d.nf) ? code : int'(d.prev);
            depth = 0;
            while (cw >= lzwd_pkg::LITERALS) begin
                rev[depth] = d.suf[cw - lzwd_pkg::LITERALS];
                depth++;
                cw = int'(d.pre[cw - lzwd_pkg::LITERALS]);
            end
            rev[depth] = 8'(cw);
            depth++;
            first = rev[depth - 1];
            for (i = 0; i < depth; i++) str[i] = rev[depth - 1 - i];
            n = depth;
            if (code >= d.nf) begin
                str[n] = d.pfirst;
                n++;
                code = d.nf & 12'hFFF;
            end
            if (d.nf < (1 << MAXB)) begin
                d.pre[d.nf - lzwd_pkg::LITERALS] = d.prev;
                d.suf[d.nf - lzwd_pkg::LITERALS] = first;
                d.nf++;
            end
            d.prev = 12'(code);
            d.pfirst = first;
        end
        k = 0;
        while (k < n) begin
            cnt = (n - k > lzwd_pkg::CHUNK_BYTES) ? lzwd_pkg::CHUNK_BYTES : n - k;
            flat = '0;
            for (i = 0; i < cnt; i++) flat[8*i +: 8] = str[k + i];
            o.bytes_lane0 = flat[63:0];
            o.bytes_lane1 = flat[127:64];
            o.bytes_lane2 = flat[191:128];
            o.bytes_lane3 = flat[255:192];
            o.bytes_lane4 = flat[319:256];
            o.bytes_lane5 = flat[383:320];
            o.bytes_lane6 = flat[447:384];
            o.bytes_lane7 = flat[511:448];
            o.byte_count = 7'(cnt);
            k += cnt;
            o.last_chunk = (k == n);
            o.code_length = 4'(d.width);
            res.push_back(o);
        end
    endfunction

    // queues one code word, optionally with junk above the current width
    task automatic push_code(input int code, input bit start, input bit junk);
        lzwd_pkg::t_in it;
        int  w;
        w = start ? lzwd_pkg::MIN_CODE_BITS : gen_dict.width;
        it.starts_stream = start;
        it.code_word = 12'(code);
        if (junk) it.code_word = 12'(code | ($urandom << w));
        decode_code(gen_dict, it, scratch_q);
        scratch_q.delete();
        pending_q.push_back(it);
    endtask

    task automatic random_stream(input int len);
        int i;
        int r;
        int mask;
        int c;
        push_code($urandom_range(0, 4095), 1'b1, 1'b0);
        for (i = 0; i < len; i++) begin
            mask = (1 << gen_dict.width) - 1;
            r = $urandom_range(0, 99);
            if (r < 50 && gen_dict.nf > lzwd_pkg::LITERALS) begin
                c = $urandom_range(lzwd_pkg::LITERALS, gen_dict.nf - 1);
            end else if (r < 68) begin
                c = $urandom_range(0, 255);
            end else if (r < 82) begin
                c = (gen_dict.nf < mask) ? gen_dict.nf : $urandom_range(0, mask);
            end else if (r < 88) begin
                c = mask;
            end else if (r < 92) begin
                c = $urandom_range(gen_dict.nf < mask ? gen_dict.nf : 0, mask);
            end else begin
                c = $urandom_range(0, mask);
            end
            push_code(c, 1'b0, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input int items);
        int len;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        while (items > 0) begin
            len = $urandom_range(20, 90);
            if (len > items - 1) len = items - 1;
            random_stream(len);
            items -= len + 1;
        end
        wait (pending_q.size() == 0);
    endtask

    task automatic report(input string name, input logic [63:0] e, input logic [63:0] a);
        if (e !== a) begin
            $display("%0t %s expected %h actual %h", $time, name, e, a);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        lzwd_pkg::t_out e;
        in_fire = i_rst_n && i_valid && !o_stall;
        out_fire = i_rst_n && o_valid && !i_stall;
        if (in_fire) decode_code(chk_dict, i_data, chunk_q);
        if (out_fire) begin
            if (chunk_q.size() == 0) begin
                $display("%0t unexpected transfer, expected none actual %h", $time, o_data);
                errors++;
            end else begin
                e = chunk_q.pop_front();
                report("bytes_lane0", e.bytes_lane0, o_data.bytes_lane0);
                report("bytes_lane1", e.bytes_lane1, o_data.bytes_lane1);
                report("bytes_lane2", e.bytes_lane2, o_data.bytes_lane2);
                report("bytes_lane3", e.bytes_lane3, o_data.bytes_lane3);
                report("bytes_lane4", e.bytes_lane4, o_data.bytes_lane4);
                report("bytes_lane5", e.bytes_lane5, o_data.bytes_lane5);
                report("bytes_lane6", e.bytes_lane6, o_data.bytes_lane6);
                report("bytes_lane7", e.bytes_lane7, o_data.bytes_lane7);
                report("byte_count", 64'(e.byte_count), 64'(o_data.byte_count));
                report("last_chunk", 64'(e.last_chunk), 64'(o_data.last_chunk));
                report("code_length", 64'(e.code_length), 64'(o_data.code_length));
            end
        end
        quiet_cycles = (in_fire || out_fire || !i_rst_n) ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // driver: a valid item is held until its transfer
    always @(negedge i_clk) begin
        if (i_rst_n && (in_fire || !i_valid)) begin
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_data <= pending_q.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial begin
        int i;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        errors = 0;
        quiet_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        in_fire = 1'b0;
        out_fire = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // first code all ones is a literal, then widen up to the maximum
        push_code(12'hFFF, 1'b1, 1'b0);
        push_code(511, 1'b0, 1'b0);
        push_code(1023, 1'b0, 1'b0);
        push_code(2047, 1'b0, 1'b0);
        push_code(4095, 1'b0, 1'b0);
        push_code(0, 1'b0, 1'b0);
        push_code(255, 1'b0, 1'b0);
        push_code(256, 1'b0, 1'b0);
        push_code(gen_dict.nf, 1'b0, 1'b0);
        push_code(gen_dict.nf + 7, 1'b0, 1'b0);
        // restart with junk above the width, then a marker and a kwkwk chain
        push_code(12'hF00, 1'b1, 1'b0);
        push_code(12'hE41, 1'b0, 1'b0);
        push_code(511, 1'b0, 1'b1);
        for (i = 0; i < 70; i++) push_code(gen_dict.nf, 1'b0, 1'b0);
        push_code(gen_dict.nf - 1, 1'b0, 1'b0);
        wait (pending_q.size() == 0);

        run_phase(0, 0, 90);
        run_phase(61, 0, 90);
        run_phase(0, 61, 90);
        run_phase(18, 18, 90);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        @(posedge i_clk);
        wait (chunk_q.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (errors == 0 && chunk_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/lzwd_pkg.sv
rtl/lzwd_front.sv
rtl/lzwd_back.sv
rtl/lzw_variable_width_decoder.sv
tb/tb_top.sv
